@@ hw/rtl/qpr_pkg.sv @@
package qpr_pkg;

  localparam int COORD_W = 32;
  localparam int COEF_W  = 16;
  localparam int QUAT_W  = 16;
  localparam int COEF_F  = COEF_W - 2;

  localparam int NUM_COEF = 9;

  // register map
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_QUAT_I    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUAT_J    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUAT_K    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_QUAT_REAL = 2'd3;

  localparam logic [QUAT_W-1:0] QUAT_REAL_RST = QUAT_W'(1 << (QUAT_W - 2));

  // matrix derivation widths
  localparam int PROD_W = 2 * QUAT_W;
  localparam int PSUM_W = PROD_W + 1;
  localparam int NORM_W = PROD_W + 1;
  localparam int QB     = COEF_F + 2;
  localparam int DIV_W  = PROD_W + QB;
  localparam int REM_W  = NORM_W + 1;

  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1 << COEF_F);

  typedef logic [NUM_COEF-1:0][COEF_W-1:0] coef_mat_t;

  typedef struct packed {
    logic busy;
    logic zero_q;
  } seq_status_t;

  function automatic coef_mat_t identity_mat();
    coef_mat_t m;
    for (int t = 0; t < NUM_COEF; t++) begin
      m[t] = ((t % 4) == 0) ? COEF_ONE : '0;
    end
    return m;
  endfunction

endpackage

@@ hw/rtl/qpr_matrix_seq.sv @@
module qpr_matrix_seq (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [qpr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [qpr_pkg::QUAT_W-1:0]       cfg_data,
  output qpr_pkg::coef_mat_t               coef_o,
  output qpr_pkg::seq_status_t             status_o
);
  import qpr_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_ADD   = 3'd2;
  localparam logic [2:0] ST_POST  = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_STORE = 3'd5;

  // jobs: two halves of the norm, then the nine coefficients row-major
  localparam logic [3:0] J_NA = 4'd0;
  localparam logic [3:0] J_NB = 4'd1;
  localparam logic [3:0] J_M0 = 4'd2;
  localparam logic [3:0] J_M1 = 4'd3;
  localparam logic [3:0] J_M2 = 4'd4;
  localparam logic [3:0] J_M3 = 4'd5;
  localparam logic [3:0] J_M4 = 4'd6;
  localparam logic [3:0] J_M5 = 4'd7;
  localparam logic [3:0] J_M6 = 4'd8;
  localparam logic [3:0] J_M7 = 4'd9;
  localparam logic [3:0] J_M8 = 4'd10;

  localparam int CNT_W = $clog2(QB);
  localparam int CW    = QB + 2;
  localparam logic signed [CW-1:0] ONE_W = CW'(1 << COEF_F);

  logic [2:0]                state_r;
  logic [3:0]                job_r;
  logic signed [QUAT_W-1:0]  quat_r [4];
  logic signed [QUAT_W-1:0]  qi, qj, qk, qr;
  logic signed [QUAT_W-1:0]  op_a, op_b, op_c, op_d;
  logic                      op_sub, op_diag;
  logic signed [PROD_W-1:0]  prod_a_r, prod_b_r;
  logic signed [PSUM_W-1:0]  psum_r, norm_a_r;
  logic [NORM_W-1:0]         norm_r, norm_sum;
  logic                      neg_r;
  logic [PROD_W-1:0]         mag;
  logic [DIV_W-1:0]          dividend;
  logic [REM_W-1:0]          rem_r, divisor;
  logic [REM_W:0]            trial;
  logic                      trial_ge;
  logic [QB-1:0]             dlo_r, quo_r;
  logic [CNT_W-1:0]          cnt_r;
  logic signed [CW-1:0]      quo_s, coef_val;
  logic [3:0]                coef_idx;
  coef_mat_t                 mat_r;
  logic                      zero_r;

  function automatic logic [COEF_W-1:0] clamp_coef(input logic signed [CW-1:0] v);
    logic [COEF_W-1:0] res;
    if (v[CW-1:COEF_W-1] == {(CW-COEF_W+1){v[CW-1]}}) begin
      res = v[COEF_W-1:0];
    end else begin
      res = v[CW-1] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
    end
    return res;
  endfunction

  assign qi = quat_r[CFG_QUAT_I];
  assign qj = quat_r[CFG_QUAT_J];
  assign qk = quat_r[CFG_QUAT_K];
  assign qr = quat_r[CFG_QUAT_REAL];

  always_comb begin
    op_a    = '0;
    op_b    = '0;
    op_c    = '0;
    op_d    = '0;
    op_sub  = 1'b0;
    op_diag = 1'b0;
    unique case (job_r)
      J_NA: begin op_a = qi; op_b = qi; op_c = qj; op_d = qj; end
      J_NB: begin op_a = qk; op_b = qk; op_c = qr; op_d = qr; end
      J_M0: begin op_a = qj; op_b = qj; op_c = qk; op_d = qk; op_diag = 1'b1; end
      J_M1: begin op_a = qi; op_b = qj; op_c = qk; op_d = qr; op_sub = 1'b1; end
      J_M2: begin op_a = qi; op_b = qk; op_c = qj; op_d = qr; end
      J_M3: begin op_a = qi; op_b = qj; op_c = qk; op_d = qr; end
      J_M4: begin op_a = qi; op_b = qi; op_c = qk; op_d = qk; op_diag = 1'b1; end
      J_M5: begin op_a = qj; op_b = qk; op_c = qi; op_d = qr; op_sub = 1'b1; end
      J_M6: begin op_a = qi; op_b = qk; op_c = qj; op_d = qr; op_sub = 1'b1; end
      J_M7: begin op_a = qj; op_b = qk; op_c = qi; op_d = qr; end
      J_M8: begin op_a = qi; op_b = qi; op_c = qj; op_d = qj; op_diag = 1'b1; end
      default: begin end
    endcase
  end

  assign norm_sum = NORM_W'(norm_a_r) + NORM_W'(psum_r);
  assign mag      = psum_r[PSUM_W-1] ? PROD_W'(-psum_r) : PROD_W'(psum_r);
  // 2*num + n with num = |P| << (F+1)
  assign dividend = (DIV_W'(mag) << QB) + DIV_W'(norm_r);
  assign divisor  = {norm_r, 1'b0};
  assign trial    = {rem_r, dlo_r[QB-1]};
  assign trial_ge = trial >= {1'b0, divisor};

  assign quo_s    = neg_r ? -$signed({2'b00, quo_r}) : $signed({2'b00, quo_r});
  assign coef_val = op_diag ? ONE_W - quo_s : quo_s;
  assign coef_idx = job_r - J_M0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r               <= ST_IDLE;
      job_r                 <= J_NA;
      quat_r[CFG_QUAT_I]    <= '0;
      quat_r[CFG_QUAT_J]    <= '0;
      quat_r[CFG_QUAT_K]    <= '0;
      quat_r[CFG_QUAT_REAL] <= QUAT_REAL_RST;
      mat_r                 <= identity_mat();
      zero_r                <= 1'b0;
    end else if (cfg_we) begin
      // any write restarts the rebuild from the current register set
      quat_r[cfg_index] <= cfg_data;
      state_r           <= ST_MUL;
      job_r             <= J_NA;
    end else begin
      unique case (state_r)
        ST_IDLE: begin end
        ST_MUL: begin
          prod_a_r <= PROD_W'(op_a) * PROD_W'(op_b);
          prod_b_r <= PROD_W'(op_c) * PROD_W'(op_d);
          state_r  <= ST_ADD;
        end
        ST_ADD: begin
          psum_r  <= op_sub ? PSUM_W'(prod_a_r) - PSUM_W'(prod_b_r)
                            : PSUM_W'(prod_a_r) + PSUM_W'(prod_b_r);
          state_r <= ST_POST;
        end
        ST_POST: begin
          if (job_r == J_NA) begin
            norm_a_r <= psum_r;
            job_r    <= J_NB;
            state_r  <= ST_MUL;
          end else if (job_r == J_NB) begin
            if (norm_sum == '0) begin
              mat_r   <= identity_mat();
              zero_r  <= 1'b1;
              state_r <= ST_IDLE;
            end else begin
              norm_r  <= norm_sum;
              zero_r  <= 1'b0;
              job_r   <= J_M0;
              state_r <= ST_MUL;
            end
          end else begin
            neg_r   <= psum_r[PSUM_W-1];
            rem_r   <= REM_W'(dividend[DIV_W-1:QB]);
            dlo_r   <= dividend[QB-1:0];
            quo_r   <= '0;
            cnt_r   <= '0;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_r <= trial_ge ? REM_W'(trial - {1'b0, divisor}) : trial[REM_W-1:0];
          quo_r <= {quo_r[QB-2:0], trial_ge};
          dlo_r <= {dlo_r[QB-2:0], 1'b0};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(QB - 1)) begin
            state_r <= ST_STORE;
          end
        end
        ST_STORE: begin
          mat_r[coef_idx] <= clamp_coef(coef_val);
          if (job_r == J_M8) begin
            state_r <= ST_IDLE;
          end else begin
            job_r   <= job_r + 1'b1;
            state_r <= ST_MUL;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign coef_o          = mat_r;
  assign status_o.busy   = (state_r != ST_IDLE);
  assign status_o.zero_q = zero_r;

endmodule

@@ hw/rtl/quaternion_point_rotator_unit.sv @@
// Each accepted point passes the input, product and result registers in order to out_valid.
// Throughput: one point per cycle unless stalled; bubbles close up when the output is stalled.
// A quaternion register write stalls the input while the matrix is rebuilt by one shared
// restoring divider at one quotient bit per cycle; a zero quaternion skips the divisions.
// Reset is synchronous, active low: quaternion (0,0,0,1.0), identity matrix, pipeline empty.
module quaternion_point_rotator_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [qpr_pkg::COORD_W-1:0]    in_x,
  input  logic signed [qpr_pkg::COORD_W-1:0]    in_y,
  input  logic signed [qpr_pkg::COORD_W-1:0]    in_z,
  input  logic signed [qpr_pkg::COORD_W-1:0]    in_w,
  input  logic                                  in_last,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [qpr_pkg::COORD_W-1:0]    out_x,
  output logic signed [qpr_pkg::COORD_W-1:0]    out_y,
  output logic signed [qpr_pkg::COORD_W-1:0]    out_z,
  output logic signed [qpr_pkg::COORD_W-1:0]    out_w,
  output logic                                  out_last,
  output logic                                  out_degenerate,
  input  logic                                  cfg_we,
  input  logic [qpr_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [qpr_pkg::QUAT_W-1:0]            cfg_data
);
  import qpr_pkg::*;

  localparam int PW = COEF_W + COORD_W;
  localparam int SW = PW + 2;
  localparam int VW = SW - COEF_F;
  localparam logic signed [SW-1:0] RND = SW'(1) << (COEF_F - 1);

  coef_mat_t                 mat;
  seq_status_t               status;

  logic                      adv_o, adv2, adv1, accept;

  logic                      s1_v_r;
  logic signed [COORD_W-1:0] s1_c_r [3];
  logic signed [COORD_W-1:0] s1_w_r;
  logic                      s1_last_r;

  logic signed [PW-1:0]      prod [NUM_COEF];
  logic                      s2_v_r;
  logic signed [PW-1:0]      s2_prod_r [NUM_COEF];
  logic signed [COORD_W-1:0] s2_w_r;
  logic                      s2_last_r;

  logic signed [SW-1:0]      row_sum [3];
  logic signed [COORD_W-1:0] row_sat [3];

  logic                      out_valid_r;
  logic signed [COORD_W-1:0] out_c_r [3];
  logic signed [COORD_W-1:0] out_w_r;
  logic                      out_last_r;
  logic                      out_degen_r;

  function automatic logic [COORD_W-1:0] sat_coord(input logic signed [VW-1:0] v);
    logic [COORD_W-1:0] res;
    if (v[VW-1:COORD_W-1] == {(VW-COORD_W+1){v[VW-1]}}) begin
      res = v[COORD_W-1:0];
    end else begin
      res = v[VW-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end
    return res;
  endfunction

  qpr_matrix_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef_o    (mat),
    .status_o  (status)
  );

  assign adv_o    = !out_valid_r || !out_stall;
  assign adv2     = !s2_v_r || adv_o;
  assign adv1     = !s1_v_r || adv2;
  assign in_stall = !adv1 || status.busy;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    for (int i = 0; i < NUM_COEF; i++) begin
      prod[i] = PW'($signed(mat[i])) * PW'(s1_c_r[i % 3]);
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_sum[r] = SW'(s2_prod_r[3*r]) + SW'(s2_prod_r[3*r+1])
                 + SW'(s2_prod_r[3*r+2]) + RND;
      row_sat[r] = sat_coord(row_sum[r][SW-1:COEF_F]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv1) begin
        s1_v_r <= accept;
      end
      if (adv2) begin
        s2_v_r <= s1_v_r;
      end
      if (adv_o) begin
        out_valid_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_c_r[0] <= in_x;
      s1_c_r[1] <= in_y;
      s1_c_r[2] <= in_z;
      s1_w_r    <= in_w;
      s1_last_r <= in_last;
    end
    if (adv2 && s1_v_r) begin
      for (int i = 0; i < NUM_COEF; i++) begin
        s2_prod_r[i] <= prod[i];
      end
      s2_w_r    <= s1_w_r;
      s2_last_r <= s1_last_r;
    end
    if (adv_o && s2_v_r) begin
      for (int r = 0; r < 3; r++) begin
        out_c_r[r] <= row_sat[r];
      end
      out_w_r     <= s2_w_r;
      out_last_r  <= s2_last_r;
      out_degen_r <= status.zero_q;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_x          = out_c_r[0];
  assign out_y          = out_c_r[1];
  assign out_z          = out_c_r[2];
  assign out_w          = out_w_r;
  assign out_last       = out_last_r;
  assign out_degenerate = out_degen_r;

endmodule

@@ hw/rtl/qpr_checker.sv @@
module qpr_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [qpr_pkg::COORD_W-1:0]        out_x,
  input logic [qpr_pkg::COORD_W-1:0]        out_y,
  input logic [qpr_pkg::COORD_W-1:0]        out_z,
  input logic [qpr_pkg::COORD_W-1:0]        out_w,
  input logic                               out_last,
  input logic                               out_degenerate,
  input logic                               cfg_we
);

  // matrix rebuild holds off new points
  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> in_stall)
    else $error("input not stalled after quaternion write");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result request dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_x) && $stable(out_y) && $stable(out_z)
      && $stable(out_w) && $stable(out_last) && $stable(out_degenerate))
    else $error("stalled result payload changed");

endmodule

bind quaternion_point_rotator_unit qpr_checker u_qpr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_x          (out_x),
  .out_y          (out_y),
  .out_z          (out_z),
  .out_w          (out_w),
  .out_last       (out_last),
  .out_degenerate (out_degenerate),
  .cfg_we         (cfg_we)
);
